@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	// Kind of a root word.
	typedef enum logic [1:0] {
		KIND_REAL    = 2'd0,
		KIND_COMPLEX = 2'd1,
		KIND_REPEAT  = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	// Square root stages, one result bit each.
	localparam int SQ_N = 32;
	// Divider stages, one quotient bit each.
	localparam int DV_N = 34;

endpackage
`default_nettype wire

@@ rtl/qrs_coef_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_coef_if
// Coefficient channel: one word holds a, b and c in signed fixed point.
// ----------------------------------------------------------------------------
interface qrs_coef_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] coef_square;
	logic signed [15:0] coef_linear;
	logic signed [15:0] coef_const;

	modport source(output valid, output coef_square, output coef_linear,
		output coef_const, input ready);
	modport sink(input valid, input coef_square, input coef_linear,
		input coef_const, output ready);
endinterface
`default_nettype wire

@@ rtl/qrs_root_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_root_if
// Root channel: one word holds one root in Q16.16 with its kind.
// ----------------------------------------------------------------------------
interface qrs_root_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] root_real;
	logic signed [31:0] root_imag;
	qrs_pkg::kind_t     root_kind;
	logic               last_root;

	modport source(output valid, output root_real, output root_imag,
		output root_kind, output last_root, input ready);
	modport sink(input valid, input root_real, input root_imag,
		input root_kind, input last_root, output ready);
endinterface
`default_nettype wire

@@ rtl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Pipelined solver of a*x^2 + b*x + c = 0 with Q16.16 roots.
// ----------------------------------------------------------------------------
// A coefficient word may enter in every cycle in which the pipeline is not
// held. An accepted word passes the products, discriminant, 32 square root
// stages, numerator setup, 34 divider stages, saturation and the output
// register, which sends one root word per cycle while the receiver is ready:
// two words for a set with two roots (distinct real or complex pair), one for
// a repeated root or a equal to zero. The whole pipeline advances together and
// holds while the output side stalls or the first of two words goes out.
module quadratic_root_solver (
	input  wire           clk,
	input  wire           arst_n,
	qrs_coef_if.sink      coef,
	qrs_root_if.source    root
);

	// Control carried with each set.
	typedef struct packed {
		qrs_pkg::kind_t     kind;
		logic               a_neg;
		logic [15:0]        a_mag;
		logic signed [31:0] nb;
	} ctl_t;

	// Square root stage contents.
	typedef struct packed {
		ctl_t        ctl;
		logic [33:0] absd;
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	// One divider lane.
	typedef struct packed {
		logic        neg;
		logic [15:0] r;
		logic [33:0] nq;
	} lane_t;

	typedef struct packed {
		ctl_t  ctl;
		lane_t x;
		lane_t y;
	} dv_t;

	// Saturated results of one set.
	typedef struct packed {
		qrs_pkg::kind_t     kind;
		logic signed [31:0] re0;
		logic signed [31:0] im0;
		logic signed [31:0] re1;
		logic signed [31:0] im1;
	} res_t;

	localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
	localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

	// One restoring division step.
	function automatic lane_t div_step(lane_t l, logic [15:0] d);
		logic [16:0] r_sh;
		logic        ge;
		lane_t       o;
		r_sh   = {l.r, l.nq[33]};
		ge     = (r_sh >= {1'b0, d});
		o      = l;
		o.r    = ge ? 16'(r_sh - {1'b0, d}) : r_sh[15:0];
		o.nq   = {l.nq[32:0], ge};
		return o;
	endfunction

	// Signed quotient of a lane.
	function automatic logic signed [35:0] lane_val(lane_t l);
		logic signed [35:0] m;
		m = signed'({2'b00, l.nq});
		return l.neg ? -m : m;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [35:0] v);
		logic signed [31:0] o;
		if (v > SAT_MAX) begin
			o = 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			o = 32'sh80000000;
		end else begin
			o = v[31:0];
		end
		return o;
	endfunction

	logic en;

	// Stage 1: capture the coefficients and form the products.
	logic               v_s1;
	logic signed [15:0] a_s1;
	logic signed [15:0] b_s1;
	logic signed [31:0] bb_s1;
	logic signed [31:0] ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef.coef_square;
			b_s1  <= coef.coef_linear;
			bb_s1 <= coef.coef_linear * coef.coef_linear;
			ac_s1 <= coef.coef_square * coef.coef_const;
		end
	end

	// Stage 2: discriminant, kind and root setup into the first square root stage.
	sq_t  sq_s   [qrs_pkg::SQ_N+1];
	logic sq_v_s [qrs_pkg::SQ_N+1];

	logic signed [34:0] disc;
	sq_t                sq_in;

	always_comb begin
		disc            = 35'(bb_s1) - (35'(ac_s1) <<< 2);
		sq_in.absd      = disc[34] ? 34'(-disc) : disc[33:0];
		sq_in.rem       = '0;
		sq_in.root      = '0;
		sq_in.ctl.a_neg = a_s1[15];
		sq_in.ctl.a_mag = a_s1[15] ? 16'(-a_s1) : 16'(a_s1);
		sq_in.ctl.nb    = -(32'(b_s1) <<< 15);
		if (a_s1 == 16'sd0) begin
			sq_in.ctl.kind = qrs_pkg::KIND_ERROR;
		end else if (disc > 35'sd0) begin
			sq_in.ctl.kind = qrs_pkg::KIND_REAL;
		end else if (disc < 35'sd0) begin
			sq_in.ctl.kind = qrs_pkg::KIND_COMPLEX;
		end else begin
			sq_in.ctl.kind = qrs_pkg::KIND_REPEAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0] <= sq_in;
		end
	end

	// Square root stages: one result bit of sqrt(|D| * 2^30) per stage.
	for (genvar k = 1; k <= qrs_pkg::SQ_N; k++) begin : g_sq
		logic [63:0] x;
		logic [35:0] rem_sh;
		logic [35:0] trial;
		logic        ge;
		sq_t         nxt;

		always_comb begin
			x        = {sq_s[k-1].absd, 30'd0};
			rem_sh   = {sq_s[k-1].rem, x[65-2*k -: 2]};
			trial    = {2'b00, sq_s[k-1].root, 2'b01};
			ge       = (rem_sh >= trial);
			nxt      = sq_s[k-1];
			nxt.rem  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
			nxt.root = {sq_s[k-1].root[30:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (en) begin
				sq_v_s[k] <= sq_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k] <= nxt;
			end
		end
	end

	// Numerator setup: two dividends per set, split into sign and magnitude.
	dv_t  dv_s   [qrs_pkg::DV_N+1];
	logic dv_v_s [qrs_pkg::DV_N+1];

	logic signed [34:0] nb35;
	logic signed [34:0] s35;
	logic signed [34:0] num_x;
	logic signed [34:0] num_y;
	dv_t                dv_in;

	always_comb begin
		nb35 = 35'(sq_s[qrs_pkg::SQ_N].ctl.nb);
		s35  = signed'({3'b000, sq_s[qrs_pkg::SQ_N].root});
		case (sq_s[qrs_pkg::SQ_N].ctl.kind)
			qrs_pkg::KIND_REAL: begin
				num_x = nb35 + s35;
				num_y = nb35 - s35;
			end
			qrs_pkg::KIND_COMPLEX: begin
				num_x = nb35;
				num_y = s35;
			end
			default: begin
				num_x = nb35;
				num_y = '0;
			end
		endcase
		dv_in.ctl   = sq_s[qrs_pkg::SQ_N].ctl;
		dv_in.x.r   = '0;
		dv_in.x.nq  = num_x[34] ? 34'(-num_x) : num_x[33:0];
		dv_in.x.neg = num_x[34] ^ dv_in.ctl.a_neg;
		dv_in.y.r   = '0;
		dv_in.y.nq  = num_y[34] ? 34'(-num_y) : num_y[33:0];
		dv_in.y.neg = num_y[34] ^ dv_in.ctl.a_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[qrs_pkg::SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dv_in;
		end
	end

	// Divider stages: one quotient bit per lane per stage.
	for (genvar k = 1; k <= qrs_pkg::DV_N; k++) begin : g_dv
		dv_t nxt;

		always_comb begin
			nxt   = dv_s[k-1];
			nxt.x = div_step(dv_s[k-1].x, dv_s[k-1].ctl.a_mag);
			nxt.y = div_step(dv_s[k-1].y, dv_s[k-1].ctl.a_mag);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (en) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= nxt;
			end
		end
	end

	// Saturation into the hold stage that feeds the output register.
	logic signed [35:0] qx;
	logic signed [35:0] qy;
	res_t               res_in;
	res_t               hold_s;
	logic               hold_v_s;

	always_comb begin
		qx          = lane_val(dv_s[qrs_pkg::DV_N].x);
		qy          = lane_val(dv_s[qrs_pkg::DV_N].y);
		res_in.kind = dv_s[qrs_pkg::DV_N].ctl.kind;
		res_in.re0  = '0;
		res_in.im0  = '0;
		res_in.re1  = '0;
		res_in.im1  = '0;
		case (dv_s[qrs_pkg::DV_N].ctl.kind)
			qrs_pkg::KIND_REAL: begin
				res_in.re0 = sat32(qx);
				res_in.re1 = sat32(qy);
			end
			qrs_pkg::KIND_COMPLEX: begin
				res_in.re0 = sat32(qx);
				res_in.re1 = sat32(qx);
				res_in.im0 = sat32(qy);
				res_in.im1 = sat32(-qy);
			end
			qrs_pkg::KIND_REPEAT: begin
				res_in.re0 = sat32(qx);
			end
			default: begin
				res_in.re0 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_s <= 1'b0;
		end else if (en) begin
			hold_v_s <= dv_v_s[qrs_pkg::DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hold_s <= res_in;
		end
	end

	// Output emitter: sends the one or two root words of the held set.
	logic               out_v_q;
	logic signed [31:0] out_re_q;
	logic signed [31:0] out_im_q;
	qrs_pkg::kind_t     out_kind_q;
	logic               out_last_q;
	logic               idx_q;
	logic               two_words;
	logic               load;
	logic               last_now;

	assign two_words = (hold_s.kind == qrs_pkg::KIND_REAL) ||
		(hold_s.kind == qrs_pkg::KIND_COMPLEX);
	assign load      = hold_v_s && (!out_v_q || root.ready);
	assign last_now  = idx_q || !two_words;
	assign en        = !hold_v_s || (load && last_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= !last_now;
			end else if (root.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_re_q   <= idx_q ? hold_s.re1 : hold_s.re0;
			out_im_q   <= idx_q ? hold_s.im1 : hold_s.im0;
			out_kind_q <= hold_s.kind;
			out_last_q <= last_now;
		end
	end

	assign coef.ready     = en;
	assign root.valid     = out_v_q;
	assign root.root_real = out_re_q;
	assign root.root_imag = out_im_q;
	assign root.root_kind = out_kind_q;
	assign root.last_root = out_last_q;

endmodule
`default_nettype wire
